[rtl/core/assert_macros.svh]
// Assertion macros used by the top-level RTL file of the pixel mapper.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define PMAP_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("assertion failed");
`define PMAP_ASSERT_IMPL(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("assertion failed");
`else
`define PMAP_ASSERT(lbl, expr)
`define PMAP_ASSERT_IMPL(lbl, pre, post)
`endif
`endif

[rtl/core/pmap_pkg.sv]
// Types, constants and register codes of the LED matrix pixel mapper.
package pmap_pkg;
  localparam int unsigned MaxPixelsDef   = 65536;
  localparam int unsigned ChannelBitsDef = 24;
  localparam int unsigned ChansPerPixel  = 3;
  localparam int unsigned CountLimit     = 256;
  localparam int unsigned CfgIdxW        = 4;
  localparam int unsigned CfgDataW       = 24;
  localparam int unsigned ChanSumW       = 34;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ORIENTATION   = 4'd0,
    REG_SINGLE_NODE   = 4'd1,
    REG_START_CORNER  = 4'd2,
    REG_NUM_STRINGS   = 4'd3,
    REG_STRANDS       = 4'd4,
    REG_PIXELS_STRAND = 4'd5,
    REG_START_CHANNEL = 4'd6,
    REG_CHAN_STRIDE   = 4'd7
  } pmap_reg_e;

  typedef struct packed {
    logic        orientation;
    logic        single_node;
    logic        ltor;
    logic        btot;
    logic [8:0]  ns;
    logic [8:0]  sp;
    logic [15:0] len;
    logic [23:0] start;
    logic [23:0] stride;
  } pmap_cfg_t;
endpackage

[rtl/core/pmap_if.sv]
// Channel interfaces: pixel input words, mapped output words, register writes.
interface pmap_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel_index;
  modport source (output valid, output pixel_index, input ready);
  modport sink (input valid, input pixel_index, output ready);
endinterface

interface pmap_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] buf_x;
  logic [15:0] buf_y;
  logic [23:0] channel;
  logic [7:0]  string_number;
  logic        out_of_range;
  modport source (output valid, output buf_x, output buf_y, output channel,
                  output string_number, output out_of_range, input ready);
  modport sink (input valid, input buf_x, input buf_y, input channel,
                input string_number, input out_of_range, output ready);
endinterface

interface pmap_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [23:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/core/led_matrix_pixel_mapper.sv]
// Top level of the serpentine LED matrix pixel mapper.
//
// A pixel index word enters on pix_i; one mapped word leaves on res_o with
// the buffer column and row, the string number, the first output channel and
// an out-of-range flag. Registers are written on cfg_i, which is always ready;
// they should only change while no word is in flight.
// The pipeline has three stages for string size, matrix size and range check,
// four stages for each of the two dividers, which resolve two quotient bits a
// stage, and two stages for the strand and channel products and the final
// mirroring.
// Throughput is one word per cycle. When the receiver stalls, the whole
// pipeline holds and pix_i is not ready while the output word waits; no word
// is lost or repeated. Reset empties the pipeline and loads the register
// defaults: vertical strands, start corner 3, one string of one strand of 50
// pixels, start channel 0 and a string stride of 150 channels.
`include "assert_macros.svh"
module led_matrix_pixel_mapper import pmap_pkg::*; #(
  parameter int unsigned MAX_PIXELS   = MaxPixelsDef,
  parameter int unsigned CHANNEL_BITS = ChannelBitsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  pmap_cfg_if.sink   cfg_i,
  pmap_in_if.sink    pix_i,
  pmap_out_if.source res_o
);
  logic        orient_q, single_q;
  logic [1:0]  corner_q;
  logic [8:0]  ns_q, sp_q;
  logic [15:0] len_q;
  logic [23:0] start_q, stride_q;
  pmap_cfg_t   cfg;
  logic        en;
  logic        fv, fo;
  logic [15:0] fidx;
  logic [23:0] fps;
  logic        d1v, d1oor;
  logic [7:0]  d1q;
  logic [15:0] d1r;
  logic        d2v;
  logic [7:0]  d2q;
  logic [15:0] d2r;
  logic [24:0] d2side;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      orient_q <= 1'b0;
      single_q <= 1'b0;
      corner_q <= 2'd3;
      ns_q     <= 9'd1;
      sp_q     <= 9'd1;
      len_q    <= 16'd50;
      start_q  <= '0;
      stride_q <= 24'd150;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_ORIENTATION:   orient_q <= cfg_i.data[0];
        REG_SINGLE_NODE:   single_q <= cfg_i.data[0];
        REG_START_CORNER:  corner_q <= cfg_i.data[1:0];
        REG_NUM_STRINGS:   ns_q     <= cfg_i.data[8:0];
        REG_STRANDS:       sp_q     <= cfg_i.data[8:0];
        REG_PIXELS_STRAND: len_q    <= cfg_i.data[15:0];
        REG_START_CHANNEL: start_q  <= cfg_i.data;
        REG_CHAN_STRIDE:   stride_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.orientation = orient_q;
    cfg.single_node = single_q;
    cfg.ltor        = corner_q[0];
    cfg.btot        = corner_q[1];
    cfg.ns          = (ns_q > 9'(CountLimit)) ? 9'(CountLimit) : ns_q;
    cfg.sp          = (sp_q > 9'(CountLimit)) ? 9'(CountLimit) : sp_q;
    cfg.len         = len_q;
    cfg.start       = start_q;
    cfg.stride      = stride_q;
  end

  assign en          = !res_o.valid || res_o.ready;
  assign pix_i.ready = en;

  pmap_front #(.MAX_PIXELS(MAX_PIXELS)) u_front (
    .clk_i, .rst_ni, .en_i(en), .cfg_i(cfg),
    .valid_i(pix_i.valid), .idx_i(pix_i.pixel_index),
    .valid_o(fv), .idx_o(fidx), .per_string_o(fps), .oor_o(fo)
  );

  pmap_div #(.DW(24), .SW(1)) u_div_string (
    .clk_i, .rst_ni, .en_i(en), .valid_i(fv), .num_i(fidx), .den_i(fps),
    .side_i(fo), .valid_o(d1v), .quo_o(d1q), .rem_o(d1r), .side_o(d1oor)
  );

  pmap_div #(.DW(16), .SW(25)) u_div_strand (
    .clk_i, .rst_ni, .en_i(en), .valid_i(d1v), .num_i(d1r), .den_i(cfg.len),
    .side_i({d1oor, d1q, d1r}), .valid_o(d2v), .quo_o(d2q), .rem_o(d2r),
    .side_o(d2side)
  );

  pmap_back #(.CHANNEL_BITS(CHANNEL_BITS)) u_back (
    .clk_i, .rst_ni, .en_i(en), .cfg_i(cfg), .valid_i(d2v),
    .s_i(d2side[23:16]), .g_i(d2q), .p_i(d2r), .rem_i(d2side[15:0]),
    .oor_i(d2side[24]),
    .valid_o(res_o.valid), .buf_x_o(res_o.buf_x), .buf_y_o(res_o.buf_y),
    .channel_o(res_o.channel), .string_o(res_o.string_number),
    .oor_o(res_o.out_of_range)
  );

  `PMAP_ASSERT(a_ready_follows_stall, pix_i.ready == (!res_o.valid || res_o.ready))
  `PMAP_ASSERT_IMPL(a_chan_zero_on_flag, res_o.valid && res_o.out_of_range, res_o.channel == '0)
  `PMAP_ASSERT_IMPL(a_cfg_ready, cfg_i.valid, cfg_i.ready)
endmodule

[rtl/core/pmap_div.sv]
// Pipelined restoring divider, two quotient bits per stage, 8-bit quotient.
module pmap_div import pmap_pkg::*; #(
  parameter int unsigned DW = 24,
  parameter int unsigned SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [15:0]   num_i,
  input  logic [DW-1:0] den_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [7:0]    quo_o,
  output logic [15:0]   rem_o,
  output logic [SW-1:0] side_o
);
  localparam int unsigned Stg = 4;
  localparam int unsigned WW  = DW + 8;

  logic          v_q [Stg];
  logic [15:0]   r_q [Stg];
  logic [7:0]    q_q [Stg];
  logic [DW-1:0] d_q [Stg];
  logic [SW-1:0] s_q [Stg];

  for (genvar j = 0; j < Stg; j++) begin : g_stg
    localparam int unsigned KH = 7 - 2 * j;
    logic          v_in;
    logic [15:0]   r_in;
    logic [7:0]    q_in;
    logic [DW-1:0] d_in;
    logic [SW-1:0] s_in;
    logic [WW-1:0] dh;
    logic [WW-1:0] dl;
    logic [15:0]   r_mid;
    logic [15:0]   r_d;
    logic          b1;
    logic          b0;

    if (j == 0) begin : g_first
      assign v_in = valid_i;
      assign r_in = num_i;
      assign q_in = '0;
      assign d_in = den_i;
      assign s_in = side_i;
    end else begin : g_next
      assign v_in = v_q[j-1];
      assign r_in = r_q[j-1];
      assign q_in = q_q[j-1];
      assign d_in = d_q[j-1];
      assign s_in = s_q[j-1];
    end

    always_comb begin
      dh    = WW'(d_in) << KH;
      dl    = WW'(d_in) << (KH - 1);
      b1    = WW'(r_in) >= dh;
      r_mid = b1 ? r_in - dh[15:0] : r_in;
      b0    = WW'(r_mid) >= dl;
      r_d   = b0 ? r_mid - dl[15:0] : r_mid;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else if (en_i) begin
        v_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[j] <= r_d;
        q_q[j] <= {q_in[5:0], b1, b0};
        d_q[j] <= d_in;
        s_q[j] <= s_in;
      end
    end
  end

  assign valid_o = v_q[Stg-1];
  assign quo_o   = q_q[Stg-1];
  assign rem_o   = r_q[Stg-1];
  assign side_o  = s_q[Stg-1];
endmodule

[rtl/core/pmap_front.sv]
// Front stages: string size, matrix size and the range check of the index.
module pmap_front import pmap_pkg::*; #(
  parameter int unsigned MAX_PIXELS = MaxPixelsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  pmap_cfg_t   cfg_i,
  input  logic        valid_i,
  input  logic [15:0] idx_i,
  output logic        valid_o,
  output logic [15:0] idx_o,
  output logic [23:0] per_string_o,
  output logic        oor_o
);
  logic        va_q, vb_q, vc_q;
  logic [15:0] idxa_q, idxb_q, idxc_q;
  logic [23:0] psa_q, psb_q, psc_q;
  logic [32:0] totb_q;
  logic        oorc_d, oorc_q;
  logic [32:0] max_c;

  assign max_c  = 33'(MAX_PIXELS);
  assign oorc_d = (psb_q == '0) || (33'(idxb_q) >= totb_q) || (33'(idxb_q) >= max_c);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      idxa_q <= idx_i;
      psa_q  <= 24'(cfg_i.sp) * 24'(cfg_i.len);
      idxb_q <= idxa_q;
      psb_q  <= psa_q;
      totb_q <= 33'(cfg_i.ns) * 33'(psa_q);
      idxc_q <= idxb_q;
      psc_q  <= psb_q;
      oorc_q <= oorc_d;
    end
  end

  assign valid_o      = vc_q;
  assign idx_o        = idxc_q;
  assign per_string_o = psc_q;
  assign oor_o        = oorc_q;
endmodule

[rtl/core/pmap_back.sv]
// Back stages: strand and channel products, then mirroring and the output word.
module pmap_back import pmap_pkg::*; #(
  parameter int unsigned CHANNEL_BITS = ChannelBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  pmap_cfg_t   cfg_i,
  input  logic        valid_i,
  input  logic [7:0]  s_i,
  input  logic [7:0]  g_i,
  input  logic [15:0] p_i,
  input  logic [15:0] rem_i,
  input  logic        oor_i,
  output logic        valid_o,
  output logic [15:0] buf_x_o,
  output logic [15:0] buf_y_o,
  output logic [23:0] channel_o,
  output logic [7:0]  string_o,
  output logic        oor_o
);
  logic                v_q, vo_q;
  logic [7:0]          s_q, g_q;
  logic [15:0]         p_q, rem_q;
  logic                oor_q;
  logic [16:0]         tp_q;
  logic [17:0]         strands_q;
  logic [31:0]         cp_q;
  logic [15:0]         t_c, tinv_c, pinv_c, bx_d, by_d;
  logic [ChanSumW-1:0] chan_c;
  logic                even_c, ovf_c;
  logic [15:0]         bx_q, by_q;
  logic [23:0]         ch_d, ch_q;
  logic [7:0]          st_q;
  logic                fo_d, fo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q  <= 1'b0;
      vo_q <= 1'b0;
    end else if (en_i) begin
      v_q  <= valid_i;
      vo_q <= v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_q       <= s_i;
      g_q       <= g_i;
      p_q       <= p_i;
      rem_q     <= rem_i;
      oor_q     <= oor_i;
      tp_q      <= 17'(s_i) * 17'(cfg_i.sp);
      strands_q <= 18'(cfg_i.ns) * 18'(cfg_i.sp);
      cp_q      <= 32'(s_i) * 32'(cfg_i.stride);
    end
  end

  always_comb begin
    t_c    = 16'(tp_q + 17'(g_q));
    tinv_c = 16'(strands_q - 18'd1 - 18'(t_c));
    pinv_c = cfg_i.len - 16'd1 - p_q;
    even_c = ~g_q[0];
    chan_c = ChanSumW'(cfg_i.start) + ChanSumW'(cp_q);
    if (!cfg_i.single_node) begin
      chan_c = chan_c + ChanSumW'(ChansPerPixel) * ChanSumW'(rem_q);
    end
    ovf_c = (chan_c >> CHANNEL_BITS) != '0;
    if (!cfg_i.orientation) begin
      bx_d = cfg_i.ltor ? t_c : tinv_c;
      if (cfg_i.single_node) begin
        by_d = even_c ? p_q : pinv_c;
      end else begin
        by_d = (cfg_i.btot == even_c) ? p_q : pinv_c;
      end
    end else begin
      by_d = cfg_i.btot ? t_c : tinv_c;
      if (cfg_i.single_node) begin
        bx_d = even_c ? p_q : pinv_c;
      end else begin
        bx_d = (cfg_i.ltor != even_c) ? pinv_c : p_q;
      end
    end
    ch_d = ovf_c ? '0 : chan_c[23:0];
    fo_d = ovf_c;
    if (oor_q) begin
      bx_d = '0;
      by_d = '0;
      ch_d = '0;
      fo_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bx_q <= bx_d;
      by_q <= by_d;
      ch_q <= ch_d;
      st_q <= oor_q ? '0 : s_q;
      fo_q <= fo_d;
    end
  end

  assign valid_o   = vo_q;
  assign buf_x_o   = bx_q;
  assign buf_y_o   = by_q;
  assign channel_o = ch_q;
  assign string_o  = st_q;
  assign oor_o     = fo_q;
endmodule

[bench/tb_led_matrix_pixel_mapper.sv]
// Self-checking testbench for the serpentine LED matrix pixel mapper.
module tb_led_matrix_pixel_mapper;
  import pmap_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CfgIdxW-1:0] RegUnused = 4'd8;
  localparam logic [CfgIdxW-1:0] RegLast   = 4'hF;
  localparam int unsigned DrainCycles = 20;

  typedef struct packed {
    logic [15:0] buf_x;
    logic [15:0] buf_y;
    logic [23:0] channel;
    logic [7:0]  string_number;
    logic        out_of_range;
  } pixel_map_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  pmap_cfg_if cfg_bus();
  pmap_in_if  pix_bus();
  pmap_out_if res_bus();

  led_matrix_pixel_mapper DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_bus.sink),
    .pix_i (pix_bus.sink),
    .res_o (res_bus.source)
  );

  always #6 clk_i = ~clk_i;

  logic        mdl_orient;
  logic        mdl_single;
  logic [1:0]  mdl_corner;
  logic [8:0]  mdl_ns;
  logic [8:0]  mdl_sp;
  logic [15:0] mdl_len;
  logic [23:0] mdl_start;
  logic [23:0] mdl_stride;

  pixel_map_t expected_maps[$];
  int         n_errors = 0;
  bit         steady_flow = 1'b0;

  function automatic pixel_map_t map_pixel(input logic [15:0] idx);
    pixel_map_t r;
    longint unsigned ns, sp, len, per_string, total, strands;
    longint unsigned s, rem, g, p, t, chan, bx, by;
    bit ltor, btot, even;
    r = '0;
    ns = (mdl_ns > 9'd256) ? 256 : mdl_ns;
    sp = (mdl_sp > 9'd256) ? 256 : mdl_sp;
    len = mdl_len;
    per_string = sp * len;
    total = ns * per_string;
    strands = ns * sp;
    ltor = mdl_corner[0];
    btot = mdl_corner[1];
    if (total > 65536) total = 65536;
    if (per_string == 0 || idx >= total) begin
      r.out_of_range = 1'b1;
      return r;
    end
    s = idx / per_string;
    rem = idx % per_string;
    g = rem / len;
    p = rem % len;
    t = s * sp + g;
    even = (g % 2) == 0;
    chan = longint'(mdl_start) + s * longint'(mdl_stride);
    if (!mdl_single) chan += ChansPerPixel * rem;
    if (!mdl_orient) begin
      bx = ltor ? t : strands - 1 - t;
      if (mdl_single) by = even ? p : len - 1 - p;
      else by = (btot == even) ? p : len - 1 - p;
    end else begin
      by = btot ? t : strands - 1 - t;
      if (mdl_single) bx = even ? p : len - 1 - p;
      else bx = (ltor != even) ? len - 1 - p : p;
    end
    if (chan >= (64'd1 << 24)) begin
      r.out_of_range = 1'b1;
      chan = 0;
    end
    r.buf_x = bx[15:0];
    r.buf_y = by[15:0];
    r.channel = chan[23:0];
    r.string_number = s[7:0];
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (steady_flow) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [23:0] data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    do @(posedge clk_i); while (!cfg_bus.ready);
    case (pmap_reg_e'(idx))
      REG_ORIENTATION:   mdl_orient = data[0];
      REG_SINGLE_NODE:   mdl_single = data[0];
      REG_START_CORNER:  mdl_corner = data[1:0];
      REG_NUM_STRINGS:   mdl_ns     = data[8:0];
      REG_STRANDS:       mdl_sp     = data[8:0];
      REG_PIXELS_STRAND: mdl_len    = data[15:0];
      REG_START_CHANNEL: mdl_start  = data;
      REG_CHAN_STRIDE:   mdl_stride = data;
      default: ;
    endcase
  endtask

  task automatic end_writes();
    cfg_bus.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_pixel(input logic [15:0] idx);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      pix_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pix_bus.valid <= 1'b1;
    pix_bus.pixel_index <= idx;
    do @(posedge clk_i); while (!pix_bus.ready);
    expected_maps = {expected_maps, map_pixel(idx)};
  endtask

  task automatic wait_idle();
    pix_bus.valid <= 1'b0;
    while (expected_maps.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_layout(input logic orient, input logic single, input logic [1:0] corner,
                            input logic [8:0] ns, input logic [8:0] sp, input logic [15:0] len,
                            input logic [23:0] start, input logic [23:0] stride);
    write_reg(REG_ORIENTATION, {23'd0, orient});
    write_reg(REG_SINGLE_NODE, {23'd0, single});
    write_reg(REG_START_CORNER, {22'd0, corner});
    write_reg(REG_NUM_STRINGS, {15'd0, ns});
    write_reg(REG_STRANDS, {15'd0, sp});
    write_reg(REG_PIXELS_STRAND, {8'd0, len});
    write_reg(REG_START_CHANNEL, start);
    write_reg(REG_CHAN_STRIDE, stride);
    end_writes();
  endtask

  task automatic test_reset_defaults();
    send_pixel(16'd0);
    send_pixel(16'd49);
    send_pixel(16'd50);
    send_pixel(16'hFFFF);
    wait_idle();
  endtask

  task automatic test_corners_and_modes();
    for (int m = 0; m < 8; m++) begin
      set_layout(m[0], m[1], m[2] ? 2'd0 : 2'd3, 9'd2, 9'd3, 16'd4, 24'd10, 24'd40);
      send_pixel(16'd0);
      send_pixel(16'd5);
      send_pixel(16'd13);
      send_pixel(16'd23);
      wait_idle();
    end
    for (int c = 0; c < 4; c++) begin
      set_layout(1'b0, 1'b0, c[1:0], 9'd2, 9'd2, 16'd3, 24'd0, 24'd18);
      send_pixel(16'd4);
      send_pixel(16'd8);
      wait_idle();
    end
  endtask

  task automatic test_edge_cases();
    // Empty matrices: every index must be flagged.
    set_layout(1'b0, 1'b0, 2'd3, 9'd0, 9'd4, 16'd4, 24'd0, 24'd1);
    send_pixel(16'd0);
    wait_idle();
    set_layout(1'b1, 1'b0, 2'd1, 9'd4, 9'd0, 16'd4, 24'd0, 24'd1);
    send_pixel(16'd0);
    wait_idle();
    set_layout(1'b0, 1'b1, 2'd2, 9'd4, 9'd4, 16'd0, 24'd0, 24'd1);
    send_pixel(16'd0);
    wait_idle();
    // Oversized counts saturate and the matrix is clipped at the pixel limit.
    set_layout(1'b1, 1'b0, 2'd0, 9'd511, 9'd300, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF);
    send_pixel(16'd0);
    send_pixel(16'hFFFF);
    wait_idle();
    // Channel overflow keeps the coordinates but flags the word.
    set_layout(1'b0, 1'b0, 2'd3, 9'd256, 9'd1, 16'd256, 24'hFFFF00, 24'h010000);
    send_pixel(16'd0);
    send_pixel(16'd100);
    send_pixel(16'd300);
    // An unused register index must leave the layout untouched.
    wait_idle();
    write_reg(RegUnused, 24'hFFFFFF);
    write_reg(RegLast, 24'd0);
    end_writes();
    send_pixel(16'd257);
    wait_idle();
  endtask

  task automatic test_random_layouts();
    logic [8:0]  ns, sp;
    logic [15:0] len, idx;
    logic [23:0] start, stride;
    longint unsigned total;
    for (int ph = 0; ph < 12; ph++) begin
      ns = ($urandom_range(0, 9) == 0) ? 9'($urandom) : 9'($urandom_range(1, 8));
      sp = ($urandom_range(0, 9) == 0) ? 9'($urandom) : 9'($urandom_range(1, 8));
      len = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 20));
      start = ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(0, 1000));
      stride = ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(1, 500));
      set_layout(1'($urandom), 1'($urandom), 2'($urandom), ns, sp, len, start, stride);
      total = longint'(ns) * longint'(sp) * longint'(len);
      steady_flow = (ph % 4) == 3;
      for (int k = 0; k < 32; k++) begin
        if (total != 0 && $urandom_range(0, 9) < 8) idx = 16'($urandom % total);
        else idx = 16'($urandom);
        send_pixel(idx);
      end
      steady_flow = 1'b0;
      wait_idle();
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && res_bus.valid && res_bus.ready) begin
      if (expected_maps.size() == 0) begin
        n_errors++;
        if (n_errors <= 10)
          $display("Unexpected word: x=%0d y=%0d", res_bus.buf_x, res_bus.buf_y);
      end else begin
        pixel_map_t e;
        e = expected_maps.pop_front();
        if (res_bus.buf_x !== e.buf_x || res_bus.buf_y !== e.buf_y ||
            res_bus.channel !== e.channel || res_bus.string_number !== e.string_number ||
            res_bus.out_of_range !== e.out_of_range) begin
          n_errors++;
          if (n_errors <= 10)
            $display("Mismatch: expected x=%0d y=%0d ch=%0d s=%0d oor=%0b, ",
                     e.buf_x, e.buf_y, e.channel, e.string_number, e.out_of_range,
                     "got x=%0d y=%0d ch=%0d s=%0d oor=%0b",
                     res_bus.buf_x, res_bus.buf_y, res_bus.channel,
                     res_bus.string_number, res_bus.out_of_range);
        end
      end
    end
  end

  int stall_left = 0;
  always @(posedge clk_i) begin
    if (steady_flow) begin
      res_bus.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      res_bus.ready <= 1'b0;
    end else begin
      res_bus.ready <= 1'b1;
      stall_left <= pick_gap();
    end
  end

  initial begin
    cfg_bus.valid = 1'b0;
    cfg_bus.index = '0;
    cfg_bus.data = '0;
    pix_bus.valid = 1'b0;
    pix_bus.pixel_index = '0;
    res_bus.ready = 1'b0;
    mdl_orient = 1'b0;
    mdl_single = 1'b0;
    mdl_corner = 2'd3;
    mdl_ns = 9'd1;
    mdl_sp = 9'd1;
    mdl_len = 16'd50;
    mdl_start = 24'd0;
    mdl_stride = 24'd150;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_corners_and_modes();
    test_edge_cases();
    test_random_layouts();
    if (n_errors == 0 && expected_maps.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #3ms;
    $display("Test completed with failures");
    $finish;
  end
endmodule

[led_matrix_pixel_mapper.f]
+incdir+rtl/core
rtl/core/pmap_pkg.sv
rtl/core/pmap_if.sv
rtl/core/pmap_div.sv
rtl/core/pmap_front.sv
rtl/core/pmap_back.sv
rtl/core/led_matrix_pixel_mapper.sv
bench/tb_led_matrix_pixel_mapper.sv
